[rtl/core/drks_pkg.sv]
// drks_pkg: types and constants for the delimited record key scanner.
// Used by delimited_record_key_scan; no dependencies.
`default_nettype none

package drks_pkg;

    typedef enum logic [1:0] {
        PH_ID     = 2'd0,
        PH_FIXED  = 2'd1,
        PH_FIELDS = 2'd2,
        PH_END    = 2'd3
    } phase_t;

    typedef logic [1:0] status_t;

    localparam status_t ST_FOUND     = 2'd0;
    localparam status_t ST_NOT_FOUND = 2'd1;
    localparam status_t ST_FORMAT    = 2'd2;

    localparam logic [7:0] FIELD_END  = 8'h7C;   // '|'
    localparam logic [7:0] RECORD_END = 8'h5E;   // '^'

    localparam int ID_BYTES     = 4;
    localparam int FIXED_BYTES  = 8;
    localparam int FIELD_COUNT  = 4;
    localparam int KEY_WIDTH    = 32;
    localparam int RESULT_WIDTH = 32;
    localparam int OUT_DATA_WIDTH = 40;

endpackage

`default_nettype wire

[rtl/core/delimited_record_key_scan.sv]
// delimited_record_key_scan: streaming record scanner that finds the record whose id
// matches search_key. Depends on drks_pkg.
`default_nettype none

// Takes one file byte per word and returns at most one result word per scan: found with
// the start offset of the matching record, not found, or a record format error with the
// number of bytes taken. A byte flagged tlast closes the scan and the next byte starts a
// new one at offset zero. One byte is accepted every cycle unless the input is stalled; a
// byte passes the input register and the scan state update, and its result is then written
// to the output register. A waiting result stalls the input only when the next byte also
// produces one. search_key is to be written only while the block is idle; the block does not enforce this.
module delimited_record_key_scan #(
    parameter int OFFSET_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,     // search_key

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,    // [7:0] data_byte
    input  wire logic        s_axis_tlast,    // last_byte

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata     // [1:0] status, [33:2] record_offset, zero pad
);

    localparam int CNT_W = 4;
    localparam int FLD_W = 3;

    // configuration
    logic [drks_pkg::KEY_WIDTH-1:0] key_reg;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // scan state
    drks_pkg::phase_t               phase_reg, phase_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic [drks_pkg::KEY_WIDTH-1:0] id_reg, id_next;
    logic [FLD_W-1:0]               fields_reg, fields_next;
    logic [OFFSET_WIDTH-1:0]        start_reg, start_next;
    logic [OFFSET_WIDTH-1:0]        offset_reg, offset_next;
    logic                           given_reg, given_next;

    // result register
    logic                  out_valid_reg;
    drks_pkg::status_t     out_status_reg;
    logic [31:0]           out_offset_reg;

    logic                           res_hit;
    drks_pkg::status_t              res_status;
    logic [OFFSET_WIDTH-1:0]        res_offset;
    logic [OFFSET_WIDTH+31:0]       res_offset_ext;
    logic [OFFSET_WIDTH-1:0]        taken;
    logic [drks_pkg::KEY_WIDTH-1:0] id_shift;
    logic [drks_pkg::KEY_WIDTH-1:0] id_merged;
    logic                           out_free;
    logic                           step;

    assign taken     = offset_reg + OFFSET_WIDTH'(1);
    assign id_shift  = {24'b0, in_byte_reg} << {cnt_reg[1:0], 3'b000};
    assign id_merged = id_reg | id_shift;

    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        id_next     = id_reg;
        fields_next = fields_reg;
        start_next  = start_reg;
        offset_next = taken;
        given_next  = given_reg;
        res_hit     = 1'b0;
        res_status  = drks_pkg::ST_FOUND;
        res_offset  = taken;

        if (!given_reg)
        begin
            unique case (phase_reg)
                drks_pkg::PH_ID:
                begin
                    id_next  = id_merged;
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(drks_pkg::ID_BYTES - 1))
                    begin
                        if (id_merged == key_reg)
                        begin
                            res_hit    = 1'b1;
                            res_status = drks_pkg::ST_FOUND;
                            res_offset = start_reg;
                            given_next = 1'b1;
                        end
                        else
                        begin
                            phase_next = drks_pkg::PH_FIXED;
                            cnt_next   = '0;
                        end
                    end
                end
                drks_pkg::PH_FIXED:
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(drks_pkg::FIXED_BYTES - 1))
                    begin
                        phase_next  = drks_pkg::PH_FIELDS;
                        fields_next = '0;
                    end
                end
                drks_pkg::PH_FIELDS:
                begin
                    if (in_byte_reg == drks_pkg::FIELD_END)
                    begin
                        fields_next = fields_reg + FLD_W'(1);
                        if (fields_reg == FLD_W'(drks_pkg::FIELD_COUNT - 1))
                            phase_next = drks_pkg::PH_END;
                    end
                end
                drks_pkg::PH_END:
                begin
                    if (in_byte_reg == drks_pkg::RECORD_END)
                    begin
                        phase_next  = drks_pkg::PH_ID;
                        cnt_next    = '0;
                        id_next     = '0;
                        fields_next = '0;
                        start_next  = taken;
                    end
                    else
                    begin
                        res_hit    = 1'b1;
                        res_status = drks_pkg::ST_FORMAT;
                        given_next = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = drks_pkg::PH_ID;
                end
            endcase

            if (in_last_reg && !res_hit)
            begin
                res_hit    = 1'b1;
                res_status = (phase_next == drks_pkg::PH_ID) ? drks_pkg::ST_NOT_FOUND
                                                             : drks_pkg::ST_FORMAT;
                res_offset = taken;
            end
        end

        if (in_last_reg)
        begin
            phase_next  = drks_pkg::PH_ID;
            cnt_next    = '0;
            id_next     = '0;
            fields_next = '0;
            start_next  = '0;
            offset_next = '0;
            given_next  = 1'b0;
        end
    end

    assign res_offset_ext = {32'b0, res_offset};
    assign out_free       = !out_valid_reg || m_axis_tready;
    assign step           = in_valid_reg && (!res_hit || out_free);
    assign s_axis_tready  = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= drks_pkg::KEY_WIDTH'(1);
        end
        else if (cfg_wr_en)
        begin
            key_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= drks_pkg::PH_ID;
            cnt_reg    <= '0;
            id_reg     <= '0;
            fields_reg <= '0;
            start_reg  <= '0;
            offset_reg <= '0;
            given_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            id_reg     <= id_next;
            fields_reg <= fields_next;
            start_reg  <= start_next;
            offset_reg <= offset_next;
            given_reg  <= given_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= step && res_hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && step && res_hit)
        begin
            out_status_reg <= res_status;
            out_offset_reg <= res_offset_ext[31:0];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_offset_reg, out_status_reg};

endmodule

`default_nettype wire
